FILE: hw/rtl/caption_cc_data_demux_core_defines.svh
// ----------------------------------------------------------------------------
// caption_cc_data_demux_core_defines
// assertion macros used by the caption demux checker
// ----------------------------------------------------------------------------
`ifndef CAPTION_CC_DATA_DEMUX_CORE_DEFINES_SVH
`define CAPTION_CC_DATA_DEMUX_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define CCDD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define CCDD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ccdd_pkg.sv
// ----------------------------------------------------------------------------
// ccdd_pkg
// types and constants of the caption transport packet demux
// ----------------------------------------------------------------------------
package ccdd_pkg;

    localparam int unsigned ChanEnW  = 3;
    localparam int unsigned CountW   = 5;
    localparam int unsigned TdataW   = 24;
    localparam int unsigned TuserW   = 5;

    localparam logic [7:0] MARKER_MASK = 8'hF8;
    localparam logic [7:0] MARKER_BYTE = 8'hFF;

    localparam logic [1:0] CH_608_F1 = 2'd0;
    localparam logic [1:0] CH_608_F2 = 2'd1;
    localparam logic [1:0] CH_708    = 2'd2;

    typedef enum logic [6:0] {
        PH_HEADER  = 7'b0000001,
        PH_EM      = 7'b0000010,
        PH_TRIPLET = 7'b0000100,
        PH_DATA1   = 7'b0001000,
        PH_DATA2   = 7'b0010000,
        PH_MARKER  = 7'b0100000,
        PH_PAD     = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic       pair_valid;
        logic [1:0] channel;
        logic [1:0] pair_type;
        logic [7:0] first_data;
        logic [7:0] second_data;
        logic       packet_end;
        logic       marker_error;
        logic       truncated;
    } result_t;

endpackage

FILE: hw/rtl/caption_cc_data_demux_core.sv
// ----------------------------------------------------------------------------
// caption_cc_data_demux_core
// splits caption transport packets into caption byte pairs
// ----------------------------------------------------------------------------
// usage:
//   the slave side takes one packet byte per word, s_tlast on the final byte.
//   the master side gives one word per delivered caption pair, and one word
//   for the final byte that carries the end report (a pair on the final byte
//   shares that word). bytes that deliver nothing give no word.
//   cfg_data writes the 3-bit channel enable; write it while the block idles.
// path: a byte waits in the input register and its result leaves from the
//   result register, which is loaded as the byte is decided.
// throughput: one byte per cycle while no result waits on the master side;
//   the byte state machine decides each byte in a single pass between the two registers.
// reset: both registers empty, parser back at the packet header, channel
//   enable set to all ones.
// stall: a held result keeps the master word steady; bytes that give no
//   result still flow, and the input stalls only when a result must wait.
// ----------------------------------------------------------------------------
module caption_cc_data_demux_core
    import ccdd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic              s_tlast,   // last_byte
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [TdataW-1:0] m_tdata,   // [7:0] first_data, [15:8] second_data,
                                         // [16] marker_error, [17] truncated
    output logic [TuserW-1:0] m_tuser,   // [0] pair_valid, [2:1] channel,
                                         // [4:3] pair_type
    output logic              m_tlast,   // packet_end
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ChanEnW-1:0] cfg_data
);

    logic [ChanEnW-1:0] chan_en_reg;
    in_word_t           s_word;
    in_word_t           in_word;
    logic               in_valid;
    logic               in_adv;
    logic               produce;
    logic               can_take;
    result_t            step_result;
    result_t            m_result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_en_reg <= '1;
        end else if (cfg_valid) begin
            chan_en_reg <= cfg_data;
        end
    end

    assign s_word.data_byte = s_tdata;
    assign s_word.last_byte = s_tlast;

    // a byte with no result never waits on the master side
    assign in_adv = in_valid && (!produce || can_take);

    ccdd_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_word   (s_word),
        .in_valid (in_valid),
        .in_word  (in_word),
        .in_adv   (in_adv)
    );

    ccdd_parser u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .chan_en  (chan_en_reg),
        .in_word  (in_word),
        .step     (in_adv),
        .produce  (produce),
        .result   (step_result)
    );

    ccdd_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (in_adv && produce),
        .load_result (step_result),
        .can_take    (can_take),
        .m_valid     (m_tvalid),
        .m_ready     (m_tready),
        .m_result    (m_result)
    );

    assign m_tdata = {6'b0, m_result.truncated, m_result.marker_error,
                      m_result.second_data, m_result.first_data};
    assign m_tuser = {m_result.pair_type, m_result.channel, m_result.pair_valid};
    assign m_tlast = m_result.packet_end;

endmodule

FILE: hw/rtl/ccdd_in_stage.sv
// ----------------------------------------------------------------------------
// ccdd_in_stage
// input register for packet bytes
// ----------------------------------------------------------------------------
module ccdd_in_stage
    import ccdd_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_word_t s_word,
    output logic     in_valid,
    output in_word_t in_word,
    input  logic     in_adv
);

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign s_ready    = !valid_reg || in_adv;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            word_reg <= s_word;
        end
    end

    assign in_valid = valid_reg;
    assign in_word  = word_reg;

endmodule

FILE: hw/rtl/ccdd_parser.sv
// ----------------------------------------------------------------------------
// ccdd_parser
// byte state machine of the packet: header, triplets, marker and padding
// ----------------------------------------------------------------------------
module ccdd_parser
    import ccdd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [ChanEnW-1:0] chan_en,
    input  in_word_t           in_word,
    input  logic               step,
    output logic               produce,
    output result_t            result
);

    phase_t              phase_reg, phase_next, phase_step;
    logic [CountW-1:0]   pairs_reg, pairs_next, pairs_step, pairs_dec;
    logic                proc_reg, proc_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [1:0]          cur_type_reg, cur_type_next;
    logic [7:0]          held_reg, held_next;
    logic                mark_bad_reg, mark_bad_next, mark_bad_step;
    logic [1:0]          chan;
    logic                emit;

    assign pairs_dec = pairs_reg - CountW'(1);
    // types 2 and 3 both belong to the 708 service
    assign chan = cur_type_reg[1] ? CH_708 : cur_type_reg;

    always_comb begin
        phase_step     = phase_reg;
        pairs_step     = pairs_reg;
        proc_next      = proc_reg;
        cur_valid_next = cur_valid_reg;
        cur_type_next  = cur_type_reg;
        held_next      = held_reg;
        mark_bad_step  = mark_bad_reg;
        emit           = 1'b0;
        unique case (phase_reg)
            PH_HEADER: begin
                proc_next  = in_word.data_byte[6];
                pairs_step = in_word.data_byte[CountW-1:0];
                phase_step = PH_EM;
            end
            PH_EM: begin
                phase_step = (pairs_reg == '0) ? PH_MARKER : PH_TRIPLET;
            end
            PH_TRIPLET: begin
                if (proc_reg && ((in_word.data_byte & MARKER_MASK) != MARKER_MASK)) begin
                    mark_bad_step = 1'b1;
                end
                cur_valid_next = in_word.data_byte[2];
                cur_type_next  = in_word.data_byte[1:0];
                phase_step     = PH_DATA1;
            end
            PH_DATA1: begin
                held_next  = in_word.data_byte;
                phase_step = PH_DATA2;
            end
            PH_DATA2: begin
                emit       = proc_reg && cur_valid_reg && chan_en[chan];
                pairs_step = pairs_dec;
                phase_step = (pairs_dec == '0) ? PH_MARKER : PH_TRIPLET;
            end
            PH_MARKER: begin
                if (in_word.data_byte != MARKER_BYTE) begin
                    mark_bad_step = 1'b1;
                end
                phase_step = PH_PAD;
            end
            PH_PAD: begin
                phase_step = PH_PAD;
            end
            default: begin
                phase_step = PH_PAD;
            end
        endcase
    end

    // end of packet rewinds to the header
    always_comb begin
        phase_next    = phase_step;
        pairs_next    = pairs_step;
        mark_bad_next = mark_bad_step;
        if (in_word.last_byte) begin
            phase_next    = PH_HEADER;
            pairs_next    = '0;
            mark_bad_next = 1'b0;
        end
    end

    assign produce = emit || in_word.last_byte;

    always_comb begin
        result              = '0;
        result.pair_valid   = emit;
        result.packet_end   = in_word.last_byte;
        if (emit) begin
            result.channel     = chan;
            result.pair_type   = cur_type_reg;
            result.first_data  = held_reg;
            result.second_data = in_word.data_byte;
        end
        if (in_word.last_byte) begin
            result.marker_error = mark_bad_step;
            result.truncated    = (phase_step != PH_PAD);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pairs_reg     <= '0;
            proc_reg      <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_type_reg  <= '0;
            held_reg      <= '0;
            mark_bad_reg  <= 1'b0;
        end else if (step) begin
            phase_reg     <= phase_next;
            pairs_reg     <= pairs_next;
            proc_reg      <= proc_next;
            cur_valid_reg <= cur_valid_next;
            cur_type_reg  <= cur_type_next;
            held_reg      <= held_next;
            mark_bad_reg  <= mark_bad_next;
        end
    end

endmodule

FILE: hw/rtl/ccdd_out_stage.sv
// ----------------------------------------------------------------------------
// ccdd_out_stage
// result register toward the master side
// ----------------------------------------------------------------------------
module ccdd_out_stage
    import ccdd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  result_t load_result,
    output logic    can_take,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            result_reg <= load_result;
        end
    end

    assign m_valid  = valid_reg;
    assign m_result = result_reg;

endmodule

FILE: hw/rtl/ccdd_checker.sv
// ----------------------------------------------------------------------------
// ccdd_checker
// port-level checks of the caption demux, bound to the top level
// ----------------------------------------------------------------------------
`include "caption_cc_data_demux_core_defines.svh"

module ccdd_checker
    import ccdd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [TdataW-1:0] m_tdata,
    input logic [TuserW-1:0] m_tuser,
    input logic              m_tlast
);

    // stalled word must hold
    `CCDD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "master word changed while stalled")

    // a word carries a pair or ends a packet
    `CCDD_ASSERT_IMPL(a_no_empty_word, aclk, aresetn, m_tvalid, m_tuser[0] || m_tlast, "word with neither pair nor packet end")

    // no pair means zeroed pair fields
    `CCDD_ASSERT_IMPL(a_pair_fields_zero, aclk, aresetn, m_tvalid && !m_tuser[0], m_tuser[4:1] == 4'd0 && m_tdata[15:0] == 16'd0, "pair fields set without a pair")

    // end flags only on the packet end word
    `CCDD_ASSERT_IMPL(a_end_flags_zero, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[17:16] == 2'd0, "end report flags set before packet end")

    // channel follows from the type
    `CCDD_ASSERT_IMPL(a_chan_type, aclk, aresetn, m_tvalid && m_tuser[0], (m_tuser[4] && m_tuser[2:1] == CH_708) || (!m_tuser[4] && m_tuser[2:1] == m_tuser[4:3]), "channel does not match pair type")

endmodule

bind caption_cc_data_demux_core ccdd_checker u_ccdd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
